// ----- design/yuvbgr_pkg.sv -----
package yuvbgr_pkg;

   // fixed-point scale of the coefficients
   localparam int FRAC_BITS = 20;
   // product and sum widths: the largest product stays below 2^29
   localparam int PROD_W = 30;
   localparam int SUM_W = 31;
   // a channel after the shift, about -260..540
   localparam int CH_W = SUM_W - FRAC_BITS;
   // g + 3r before its shift
   localparam int YEL_W = CH_W + 2;

   localparam logic [7:0] LUMA_FLOOR = 8'd16;

   localparam logic signed [PROD_W-1:0] COEF_Y = 30'sd1220542;
   localparam logic signed [PROD_W-1:0] COEF_UB = 30'sd2116026;
   localparam logic signed [PROD_W-1:0] COEF_UG = -30'sd409993;
   localparam logic signed [PROD_W-1:0] COEF_VG = -30'sd852492;
   localparam logic signed [PROD_W-1:0] COEF_VR = 30'sd1673527;
   localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) <<< (FRAC_BITS - 1);

   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [SUM_W-1:0] sum_type;
   typedef logic signed [CH_W-1:0] chan_type;

   function automatic logic [7:0] sat8(input chan_type x);
      logic [7:0] r;
      if (x < 0) begin
         r = 8'd0;
      end else if (x > chan_type'(255)) begin
         r = 8'd255;
      end else begin
         r = x[7:0];
      end
      return r;
   endfunction

endpackage

// ----- design/yuv422_pair_to_bgr_and_yellow_gray_core.sv -----
// an accepted req word passes through the s1, s2, s3 and rsp registers in order to its rsp word
// throughput: one pixel pair per cycle while the pipe is not halted; a four-stage multiply/add/saturate pipe
// the whole pipe advances together and halts while rsp_tvalid is high and rsp_tready low
// reset: synchronous, active high; clears the stage valid bits only
module yuv422_pair_to_bgr_and_yellow_gray_core
   import yuvbgr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // luma_first, luma_second, chroma_blue, chroma_red
   input  logic [31:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // blue_first, green_first, red_first, blue_second, green_second, red_second,
   // yellow_first, yellow_second
   output logic [63:0] rsp_tdata
);

   logic advance;

   // stage 1: luma clamp and chroma offset
   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] y0_ff, y0_in, y1_ff, y1_in;
   logic signed [7:0] u_ff, u_in, v_ff, v_in;

   // stage 2: products
   logic     s2_valid_ff;
   prod_type t0_ff, t0_in, t1_ff, t1_in;
   prod_type pr_ff, pr_in, pb_ff, pb_in, pgu_ff, pgu_in, pgv_ff, pgv_in;

   // stage 3: rounded, shifted channels
   logic     s3_valid_ff;
   chan_type r0_ff, r0_in, g0_ff, g0_in, b0_ff, b0_in;
   chan_type r1_ff, r1_in, g1_ff, g1_in, b1_ff, b1_in;

   // stage 4: saturated output word
   logic        rsp_valid_ff;
   logic [63:0] rsp_data_ff, rsp_data_in;

   assign advance = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;
   assign s1_valid_in = req_tvalid;

   always_comb begin
      logic [7:0] lf, ls, cb, cr;
      lf = req_tdata[7:0];
      ls = req_tdata[15:8];
      cb = req_tdata[23:16];
      cr = req_tdata[31:24];
      y0_in = (lf < LUMA_FLOOR) ? 8'd0 : lf - LUMA_FLOOR;
      y1_in = (ls < LUMA_FLOOR) ? 8'd0 : ls - LUMA_FLOOR;
      // subtracting 128 is flipping the top bit
      u_in = signed'({~cb[7], cb[6:0]});
      v_in = signed'({~cr[7], cr[6:0]});
   end

   always_comb begin
      prod_type y0x, y1x, ux, vx;
      y0x = prod_type'(signed'({1'b0, y0_ff}));
      y1x = prod_type'(signed'({1'b0, y1_ff}));
      ux = prod_type'(u_ff);
      vx = prod_type'(v_ff);
      t0_in = y0x * COEF_Y;
      t1_in = y1x * COEF_Y;
      pr_in = vx * COEF_VR;
      pb_in = ux * COEF_UB;
      pgu_in = ux * COEF_UG;
      pgv_in = vx * COEF_VG;
   end

   always_comb begin
      sum_type sr0, sg0, sb0, sr1, sg1, sb1, gsum;
      gsum = sum_type'(pgu_ff) + sum_type'(pgv_ff);
      sr0 = sum_type'(t0_ff) + sum_type'(pr_ff) + ROUND_HALF;
      sg0 = sum_type'(t0_ff) + gsum + ROUND_HALF;
      sb0 = sum_type'(t0_ff) + sum_type'(pb_ff) + ROUND_HALF;
      sr1 = sum_type'(t1_ff) + sum_type'(pr_ff) + ROUND_HALF;
      sg1 = sum_type'(t1_ff) + gsum + ROUND_HALF;
      sb1 = sum_type'(t1_ff) + sum_type'(pb_ff) + ROUND_HALF;
      // floor shift: keep the top bits of the two's complement sum
      r0_in = sr0[SUM_W-1:FRAC_BITS];
      g0_in = sg0[SUM_W-1:FRAC_BITS];
      b0_in = sb0[SUM_W-1:FRAC_BITS];
      r1_in = sr1[SUM_W-1:FRAC_BITS];
      g1_in = sg1[SUM_W-1:FRAC_BITS];
      b1_in = sb1[SUM_W-1:FRAC_BITS];
   end

   always_comb begin
      logic signed [YEL_W-1:0] ys0, ys1;
      // yellow gray from the unsaturated channels
      ys0 = YEL_W'(g0_ff) + YEL_W'(r0_ff) + (YEL_W'(r0_ff) <<< 1);
      ys1 = YEL_W'(g1_ff) + YEL_W'(r1_ff) + (YEL_W'(r1_ff) <<< 1);
      rsp_data_in = {sat8(ys1[YEL_W-1:2]), sat8(ys0[YEL_W-1:2]),
                     sat8(r1_ff), sat8(g1_ff), sat8(b1_ff),
                     sat8(r0_ff), sat8(g0_ff), sat8(b0_ff)};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         y0_ff <= y0_in;
         y1_ff <= y1_in;
         u_ff <= u_in;
         v_ff <= v_in;
         t0_ff <= t0_in;
         t1_ff <= t1_in;
         pr_ff <= pr_in;
         pb_ff <= pb_in;
         pgu_ff <= pgu_in;
         pgv_ff <= pgv_in;
         r0_ff <= r0_in;
         g0_ff <= g0_in;
         b0_ff <= b0_in;
         r1_ff <= r1_in;
         g1_ff <= g1_in;
         b1_ff <= b1_in;
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

endmodule

// ----- design/yuvbgr_checker.sv -----
module yuvbgr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata
);

   // a stalled rsp word stays and holds its data
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp word dropped or changed while stalled");

   // an empty output register never blocks the input
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("req_tready low with no rsp word pending");

   // an accepted word comes out if rsp_tready stays high while it passes the pipe
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready ##1 rsp_tready ##1 rsp_tready ##1 rsp_tready
      |=> rsp_tvalid)
      else $error("rsp word missing after pipeline latency");

   // full red and green force full yellow for the first pixel
   a_yellow_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[23:16] == 8'd255 && rsp_tdata[15:8] == 8'd255
      |-> rsp_tdata[55:48] == 8'd255)
      else $error("yellow not saturated with red and green at full scale");

endmodule

bind yuv422_pair_to_bgr_and_yellow_gray_core yuvbgr_checker u_yuvbgr_checker (
   .clock(clock),
   .reset(reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata)
);

// ----- tb/sv/yuv422_pair_to_bgr_and_yellow_gray_core_tb.sv -----
module yuv422_pair_to_bgr_and_yellow_gray_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint Y_GAIN = 1220542;
   localparam longint CB_TO_BLUE = 2116026;
   localparam longint CB_TO_GREEN = -409993;
   localparam longint CR_TO_GREEN = -852492;
   localparam longint CR_TO_RED = 1673527;
   localparam int SCALE_SHIFT = 20;
   localparam longint BLACK_LEVEL = 16;
   localparam longint CHROMA_ZERO = 128;

   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 80;
   localparam int DRAIN_CYCLES = 12;

   // packed from the msb down, so the last field lands in the lowest byte
   typedef struct packed {
      logic [7:0] chroma_red;
      logic [7:0] chroma_blue;
      logic [7:0] luma_second;
      logic [7:0] luma_first;
   } pair_word_type;

   typedef struct packed {
      logic [7:0] yellow_second;
      logic [7:0] yellow_first;
      logic [7:0] red_second;
      logic [7:0] green_second;
      logic [7:0] blue_second;
      logic [7:0] red_first;
      logic [7:0] green_first;
      logic [7:0] blue_first;
   } bgr_word_type;

   typedef struct {
      pair_word_type word;
      int unsigned gap;
   } pending_pair_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   // luma_first, luma_second, chroma_blue, chroma_red
   logic [31:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   // blue_first, green_first, red_first, blue_second, green_second, red_second,
   // yellow_first, yellow_second
   logic [63:0] rsp_tdata;

   logic req_fire = 1'b0;
   logic rsp_fire = 1'b0;
   logic hold_armed = 1'b0;

   pending_pair_type pair_queue[$];
   bgr_word_type expected_pixels[$];
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;

   yuv422_pair_to_bgr_and_yellow_gray_core dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [7:0] clip_byte(input longint x);
      logic [7:0] r;
      if (x < 0) begin
         r = 8'd0;
      end else if (x > 255) begin
         r = 8'd255;
      end else begin
         r = x[7:0];
      end
      return r;
   endfunction

   function automatic bgr_word_type convert_pair(input pair_word_type p);
      longint y0, y1, cb, cr, red_uv, green_uv, blue_uv;
      longint r0, g0, b0, r1, g1, b1;
      bgr_word_type w;
      y0 = longint'(p.luma_first) - BLACK_LEVEL;
      y1 = longint'(p.luma_second) - BLACK_LEVEL;
      cb = longint'(p.chroma_blue) - CHROMA_ZERO;
      cr = longint'(p.chroma_red) - CHROMA_ZERO;
      if (y0 < 0) y0 = 0;
      if (y1 < 0) y1 = 0;
      y0 = y0 * Y_GAIN;
      y1 = y1 * Y_GAIN;
      // rounding half folded into the chroma terms
      red_uv = (longint'(1) << (SCALE_SHIFT - 1)) + CR_TO_RED * cr;
      green_uv = (longint'(1) << (SCALE_SHIFT - 1)) + CR_TO_GREEN * cr + CB_TO_GREEN * cb;
      blue_uv = (longint'(1) << (SCALE_SHIFT - 1)) + CB_TO_BLUE * cb;
      // >>> on a signed longint floors toward minus infinity
      r0 = (y0 + red_uv) >>> SCALE_SHIFT;
      g0 = (y0 + green_uv) >>> SCALE_SHIFT;
      b0 = (y0 + blue_uv) >>> SCALE_SHIFT;
      r1 = (y1 + red_uv) >>> SCALE_SHIFT;
      g1 = (y1 + green_uv) >>> SCALE_SHIFT;
      b1 = (y1 + blue_uv) >>> SCALE_SHIFT;
      w.blue_first = clip_byte(b0);
      w.green_first = clip_byte(g0);
      w.red_first = clip_byte(r0);
      w.blue_second = clip_byte(b1);
      w.green_second = clip_byte(g1);
      w.red_second = clip_byte(r1);
      // yellow gray uses the unclipped channels
      w.yellow_first = clip_byte((g0 + 3 * r0) >>> 2);
      w.yellow_second = clip_byte((g1 + 3 * r1) >>> 2);
      return w;
   endfunction

   task automatic compare_field(input string name, input logic [7:0] exp_val,
                                input logic [7:0] got_val);
      if (got_val !== exp_val) begin
         $error("%s: expected %0d, got %0d", name, exp_val, got_val);
         mismatch_count++;
      end
   endtask

   // request driver: each pending pair waits out its own gap before it is offered
   int unsigned req_waited = 0;
   always @(negedge clock) begin
      pending_pair_type next_pair;
      if (!reset && (!req_tvalid || req_fire)) begin
         if (pair_queue.size() == 0) begin
            req_tvalid <= 1'b0;
         end else if (req_waited < pair_queue[0].gap) begin
            req_waited++;
            req_tvalid <= 1'b0;
         end else begin
            next_pair = pair_queue.pop_front();
            req_waited = 0;
            req_tdata <= next_pair.word;
            req_tvalid <= 1'b1;
         end
      end
   end

   // response side backpressure, with one long hold-off when armed
   int unsigned rsp_stall_left = 0;
   bit rsp_no_stall = 1'b0;
   bit hold_done = 1'b0;
   always @(negedge clock) begin
      if (hold_armed && !hold_done) begin
         rsp_stall_left = HOLD_CYCLES;
         hold_done = 1'b1;
      end else if (rsp_fire) begin
         if ($urandom_range(0, 39) == 0) rsp_no_stall = !rsp_no_stall;
         rsp_stall_left = rsp_no_stall ? 0 : $urandom_range(0, 19);
      end
      if (reset || rsp_stall_left > 0) begin
         if (rsp_stall_left > 0) rsp_stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // monitor: predicts on every accepted req word and checks every rsp word
   always @(posedge clock) begin
      bgr_word_type got, exp_pixels;
      req_fire <= !reset && req_tvalid && req_tready;
      rsp_fire <= !reset && rsp_tvalid && rsp_tready;
      if (!reset) begin
         if ($isunknown(rsp_tvalid) || $isunknown(req_tready)) begin
            $error("handshake: expected known values, got req_tready=%b rsp_tvalid=%b",
                   req_tready, rsp_tvalid);
            mismatch_count++;
         end
         if (req_tvalid && req_tready) expected_pixels.push_back(convert_pair(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (expected_pixels.size() == 0) begin
               $error("rsp word: expected none, got %h", got);
               mismatch_count++;
            end else begin
               exp_pixels = expected_pixels.pop_front();
               compare_field("blue_first", exp_pixels.blue_first, got.blue_first);
               compare_field("green_first", exp_pixels.green_first, got.green_first);
               compare_field("red_first", exp_pixels.red_first, got.red_first);
               compare_field("blue_second", exp_pixels.blue_second, got.blue_second);
               compare_field("green_second", exp_pixels.green_second, got.green_second);
               compare_field("red_second", exp_pixels.red_second, got.red_second);
               compare_field("yellow_first", exp_pixels.yellow_first, got.yellow_first);
               compare_field("yellow_second", exp_pixels.yellow_second, got.yellow_second);
            end
         end
      end
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic queue_pair(input logic [7:0] y0, input logic [7:0] y1,
                             input logic [7:0] cb, input logic [7:0] cr,
                             input int unsigned gap);
      pending_pair_type item;
      item.word = {cr, cb, y1, y0};
      item.gap = gap;
      pair_queue.push_back(item);
   endtask

   // mostly uniform, with extra weight near black level and the top of the range
   function automatic logic [7:0] pick_sample();
      logic [7:0] s;
      case ($urandom_range(0, 7))
         0: s = 8'($urandom_range(0, 17));
         1: s = 8'($urandom_range(238, 255));
         default: s = 8'($urandom_range(0, 255));
      endcase
      return s;
   endfunction

   task automatic queue_random_pairs(input int unsigned count, input bit never_idle);
      bit burst;
      burst = 1'b0;
      for (int unsigned i = 0; i < count; i++) begin
         if ($urandom_range(0, 29) == 0) burst = !burst;
         queue_pair(pick_sample(), pick_sample(), pick_sample(), pick_sample(),
                    (never_idle || burst) ? 0 : $urandom_range(0, 19));
      end
   endtask

   task automatic wait_until_drained();
      while (pair_queue.size() != 0 || req_tvalid || expected_pixels.size() != 0)
         @(negedge clock);
      @(posedge clock);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // corners: black, white, neutral gray, black level edges, clipping on each channel
      queue_pair(8'd0, 8'd0, 8'd0, 8'd0, $urandom_range(0, 19));
      queue_pair(8'd255, 8'd255, 8'd255, 8'd255, $urandom_range(0, 19));
      queue_pair(8'd16, 8'd16, 8'd128, 8'd128, 0);
      queue_pair(8'd15, 8'd16, 8'd128, 8'd128, 0);
      queue_pair(8'd17, 8'd15, 8'd128, 8'd128, $urandom_range(0, 19));
      queue_pair(8'd235, 8'd235, 8'd128, 8'd128, 0);
      queue_pair(8'd255, 8'd0, 8'd255, 8'd128, $urandom_range(0, 19));
      queue_pair(8'd0, 8'd255, 8'd0, 8'd128, 0);
      queue_pair(8'd128, 8'd128, 8'd128, 8'd255, 0);
      queue_pair(8'd128, 8'd128, 8'd128, 8'd0, $urandom_range(0, 19));
      queue_pair(8'd16, 8'd16, 8'd0, 8'd0, 0);
      queue_pair(8'd255, 8'd255, 8'd0, 8'd0, 0);
      queue_pair(8'd0, 8'd0, 8'd255, 8'd255, $urandom_range(0, 19));
      queue_pair(8'd16, 8'd235, 8'd255, 8'd0, 0);
      queue_pair(8'd235, 8'd16, 8'd0, 8'd255, 0);
      queue_pair(8'd82, 8'd145, 8'd90, 8'd240, $urandom_range(0, 19));
      queue_pair(8'd41, 8'd210, 8'd240, 8'd110, 0);
      queue_pair(8'd16, 8'd16, 8'd128, 8'd255, 0);
      queue_pair(8'd0, 8'd255, 8'd170, 8'd85, $urandom_range(0, 19));
      queue_pair(8'd85, 8'd170, 8'd85, 8'd170, 0);
      queue_pair(8'd1, 8'd254, 8'd127, 8'd129, 0);

      queue_random_pairs(300, 1'b0);

      // sender pauses until the pipe is empty, then the receiver stalls
      // while back-to-back words pile up behind it
      wait_until_drained();
      hold_armed = 1'b1;
      queue_random_pairs(100, 1'b1);

      queue_random_pairs(350, 1'b0);

      wait_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_pixels.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
